FILE: sv/sptrs_pkg.sv
// ----------------------------------------------------------------------------
// Sparse triangular row solver: shared types and constants
// Request and response layouts, the operation codes of the double-precision
// unit and the structs that connect that unit to the solver core.
// ----------------------------------------------------------------------------
package sptrs_pkg;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 80;

   // request tdata layout, lowest bit first
   localparam int ROW_LSB  = 0;
   localparam int RHS_LSB  = 16;
   localparam int COEF_LSB = 80;
   localparam int COL_LSB  = 144;

   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

   typedef enum logic {
      FPU_MUL,
      FPU_SUB
   } fpu_op_type;

   typedef struct packed {
      logic       start;
      fpu_op_type op;
      logic [63:0] a;
      logic [63:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } fpu_rsp_type;

endpackage

FILE: sv/sparse_triangular_row_solver_core.sv
// ----------------------------------------------------------------------------
// Sparse triangular row solver core
// Solves L x = b from a stream of CSR nonzeros in level-set row order and
// returns each solved row with its value.
// ----------------------------------------------------------------------------
// One request carries one nonzero. A request is taken into a one-deep holding
// register while the previous one is still at work; a further request waits
// until the core takes the held one, so a stalled response side also stalls
// the request side. An off-diagonal entry takes one memory read of the
// solution word, then a double multiply and a double subtract in the shared
// multi-cycle floating-point unit, which does one 27x27 partial product, one
// alignment step or one normalisation step per cycle. A last entry takes one
// multiply, then the solution write and the response register load. A
// subnormal result adds a shift pass down to the minimum exponent; a zero,
// infinite or NaN operand skips the arithmetic steps of that operation. The
// solution memory is a single-port read, single-port write RAM of MAX_ROWS
// words (at most 65536), with a registered read. Reading a solution word
// before it was written returns an undefined value.
// ----------------------------------------------------------------------------
module sparse_triangular_row_solver_core #(
   parameter int unsigned MAX_ROWS = 65536
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // row_index[15:0], rhs_bits[79:16], coef_bits[143:80], column_index[159:144]
   input  logic [sptrs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // first_of_row
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // solved_row[15:0], solution_bits[79:16]
   output logic [sptrs_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import sptrs_pkg::*;

   localparam int unsigned DEPTH = (MAX_ROWS < 65536) ? MAX_ROWS : 65536;
   localparam int AW = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MUL_P,
      S_SUB,
      S_MUL_Q,
      S_EMIT
   } state_type;

   state_type               state_ff;
   logic                    hold_v_ff;
   logic [REQ_DATA_W-1:0]   hold_data_ff;
   logic                    hold_first_ff;
   logic                    hold_last_ff;
   logic [15:0]             row_ff;
   logic [63:0]             coef_ff;
   logic [63:0]             acc_ff;
   logic                    col_ok_ff;
   logic                    rsp_v_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   fpu_req_type             fpu_req_ff;
   fpu_rsp_type             fpu_rsp;

   logic [63:0]             sol_mem [DEPTH];
   logic [63:0]             rdata_ff;

   logic [15:0]             hold_row, hold_col;
   logic [63:0]             hold_rhs, hold_coef;
   logic                    row_ok, rsp_free, mem_we;

   assign hold_row  = hold_data_ff[ROW_LSB +: 16];
   assign hold_rhs  = hold_data_ff[RHS_LSB +: 64];
   assign hold_coef = hold_data_ff[COEF_LSB +: 64];
   assign hold_col  = hold_data_ff[COL_LSB +: 16];

   assign req_tready = !hold_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign row_ok     = 32'(row_ff) < MAX_ROWS;
   assign rsp_free   = !rsp_v_ff || rsp_tready;
   assign mem_we     = (state_ff == S_EMIT) && rsp_free && row_ok;

   sptrs_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req_ff),
      .rsp   (fpu_rsp)
   );

   always_ff @(posedge clock) begin
      if (mem_we) sol_mem[row_ff[AW-1:0]] <= fpu_rsp.result;
      rdata_ff <= sol_mem[hold_col[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         hold_v_ff        <= 1'b0;
         rsp_v_ff         <= 1'b0;
         acc_ff           <= 64'd0;
         fpu_req_ff.start <= 1'b0;
      end else begin
         // launch one operation on the last entry, after the read, and
         // when the product is ready for the subtract
         fpu_req_ff.start <= ((state_ff == S_IDLE) && hold_v_ff && hold_last_ff) ||
                             (state_ff == S_READ) ||
                             ((state_ff == S_MUL_P) && fpu_rsp.done);
         if ((state_ff == S_EMIT) && rsp_free) rsp_v_ff <= 1'b1;
         else if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         if (req_tvalid && req_tready) begin
            hold_v_ff     <= 1'b1;
            hold_data_ff  <= req_tdata;
            hold_first_ff <= req_tuser;
            hold_last_ff  <= req_tlast;
         end
         case (state_ff)
            S_IDLE: begin
               if (hold_v_ff) begin
                  hold_v_ff <= 1'b0;
                  row_ff    <= hold_row;
                  coef_ff   <= hold_coef;
                  if (hold_first_ff) acc_ff <= hold_rhs;
                  if (hold_last_ff) begin
                     fpu_req_ff.op    <= FPU_MUL;
                     fpu_req_ff.a     <= hold_first_ff ? hold_rhs : acc_ff;
                     fpu_req_ff.b     <= hold_coef;
                     state_ff         <= S_MUL_Q;
                  end else begin
                     // solution word arrives in the next cycle
                     col_ok_ff <= 32'(hold_col) < MAX_ROWS;
                     state_ff  <= S_READ;
                  end
               end
            end
            S_READ: begin
               fpu_req_ff.op    <= FPU_MUL;
               fpu_req_ff.a     <= coef_ff;
               fpu_req_ff.b     <= col_ok_ff ? rdata_ff : 64'd0;
               state_ff         <= S_MUL_P;
            end
            S_MUL_P: begin
               if (fpu_rsp.done) begin
                  fpu_req_ff.op    <= FPU_SUB;
                  fpu_req_ff.a     <= acc_ff;
                  fpu_req_ff.b     <= fpu_rsp.result;
                  state_ff         <= S_SUB;
               end
            end
            S_SUB: begin
               if (fpu_rsp.done) begin
                  acc_ff   <= fpu_rsp.result;
                  state_ff <= S_IDLE;
               end
            end
            S_MUL_Q: begin
               if (fpu_rsp.done) state_ff <= S_EMIT;
            end
            S_EMIT: begin
               // hold the product until the response register frees up
               if (rsp_free) begin
                  rsp_data_ff <= {fpu_rsp.result, row_ff};
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   ap_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      fpu_rsp.done |-> (state_ff == S_MUL_P || state_ff == S_SUB || state_ff == S_MUL_Q))
      else $error("floating-point unit finished with no operation pending");

   ap_start_enters_wait: assert property (@(posedge clock) disable iff (reset)
      fpu_req_ff.start |-> (state_ff == S_MUL_P || state_ff == S_SUB || state_ff == S_MUL_Q))
      else $error("floating-point operation started outside a wait state");

   ap_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(state_ff == S_EMIT))
      else $error("response raised outside the emit state");

   ap_hold_kept: assert property (@(posedge clock) disable iff (reset)
      (hold_v_ff && state_ff != S_IDLE) |=> hold_v_ff)
      else $error("held request lost while the core was busy");

endmodule

FILE: sv/sptrs_fpu.sv
// ----------------------------------------------------------------------------
// Sparse triangular row solver: multi-cycle double-precision unit
// Computes a * b or a - b with IEEE double round-to-nearest-even. One 27x27
// partial product, one alignment step or one normalisation step per cycle.
// ----------------------------------------------------------------------------
module sptrs_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  sptrs_pkg::fpu_req_type req,
   output sptrs_pkg::fpu_rsp_type rsp
);
   import sptrs_pkg::*;

   localparam int MW = 128;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_SHIFT,
      F_ADD,
      F_NORM,
      F_ROUND,
      F_DONE
   } fstate_type;

   fstate_type         state_ff;
   logic               sign_ff;
   logic signed [13:0] exp_ff;
   logic [MW-1:0]      m_ff;
   logic [MW-1:0]      big_ff;
   logic [52:0]        pa_ff;
   logic [52:0]        pb_ff;
   logic [1:0]         cnt_ff;
   logic [2:0]         lvl_ff;
   logic [7:0]         sh_ff;
   logic               to_round_ff;
   logic               eff_sub_ff;
   logic [63:0]        res_ff;

   // operand decode
   logic        sa, sb;
   logic [10:0] ea, eb, ea_eff, eb_eff;
   logic [51:0] fa, fb;
   logic [52:0] ma, mb;
   logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
   logic [63:0] qa, qb;
   logic        a_big;
   logic [10:0] e_diff;
   logic [7:0]  align_sh;
   logic        spec;
   logic [63:0] spec_val;

   always_comb begin
      sa     = req.a[63];
      sb     = req.b[63];
      ea     = req.a[62:52];
      eb     = req.b[62:52];
      fa     = req.a[51:0];
      fb     = req.b[51:0];
      ea_eff = (ea == 11'd0) ? 11'd1 : ea;
      eb_eff = (eb == 11'd0) ? 11'd1 : eb;
      ma     = {ea != 11'd0, fa};
      mb     = {eb != 11'd0, fb};
      nan_a  = (ea == 11'h7FF) && (fa != 52'd0);
      nan_b  = (eb == 11'h7FF) && (fb != 52'd0);
      inf_a  = (ea == 11'h7FF) && (fa == 52'd0);
      inf_b  = (eb == 11'h7FF) && (fb == 52'd0);
      zero_a = (ea == 11'd0) && (fa == 52'd0);
      zero_b = (eb == 11'd0) && (fb == 52'd0);
      qa     = req.a | 64'h0008_0000_0000_0000;
      qb     = req.b | 64'h0008_0000_0000_0000;
      a_big  = req.a[62:0] >= req.b[62:0];
      e_diff = a_big ? (ea_eff - eb_eff) : (eb_eff - ea_eff);
      align_sh = (e_diff > 11'd255) ? 8'hFF : e_diff[7:0];
      spec     = 1'b1;
      spec_val = DEFAULT_NAN;
      case (req.op)
         FPU_MUL: begin
            if (nan_a) spec_val = qa;
            else if (nan_b) spec_val = qb;
            else if ((inf_a && zero_b) || (zero_a && inf_b)) spec_val = DEFAULT_NAN;
            else if (inf_a || inf_b) spec_val = {sa ^ sb, 11'h7FF, 52'd0};
            else if (zero_a || zero_b) spec_val = {sa ^ sb, 63'd0};
            else spec = 1'b0;
         end
         FPU_SUB: begin
            if (nan_a) spec_val = qa;
            else if (nan_b) spec_val = qb;
            else if (inf_a && inf_b && (sa == sb)) spec_val = DEFAULT_NAN;
            else if (inf_a) spec_val = req.a;
            else if (inf_b) spec_val = {~sb, req.b[62:0]};
            else if (zero_a && zero_b) spec_val = {sa & ~sb, 63'd0};
            else if (zero_b) spec_val = req.a;
            else if (zero_a) spec_val = {~sb, req.b[62:0]};
            else spec = 1'b0;
         end
         default: spec = 1'b1;
      endcase
   end

   // step datapath
   logic [7:0]         step_k;
   logic [MW-1:0]      lowmask, himask, shr_val, norm_val;
   logic               norm_hit;
   logic signed [13:0] norm_exp, undershoot;
   logic [7:0]         denorm_sh;
   logic [26:0]        op_x, op_y;
   logic [53:0]        pp;
   logic [6:0]         pp_sh;
   logic [MW-1:0]      mul_acc, add_sum;
   logic [52:0]        mant;
   logic               rnd_inc;
   logic [53:0]        rsum;
   logic [52:0]        mant_r;
   logic signed [13:0] exp_r;
   logic [63:0]        rnd_val;

   always_comb begin
      step_k   = 8'd1 << lvl_ff;
      lowmask  = ~({MW{1'b1}} << step_k);
      himask   = ~({MW{1'b1}} >> step_k);
      shr_val  = (m_ff >> step_k) | {{(MW-1){1'b0}}, |(m_ff & lowmask)};
      norm_hit = (m_ff & himask) == '0;
      norm_val = norm_hit ? (m_ff << step_k) : m_ff;
      norm_exp = norm_hit ? (exp_ff - 14'(step_k)) : exp_ff;
      undershoot = 14'sd1 - norm_exp;
      denorm_sh  = (undershoot > 14'sd255) ? 8'hFF : undershoot[7:0];

      op_x    = cnt_ff[1] ? {1'b0, pa_ff[52:27]} : pa_ff[26:0];
      op_y    = cnt_ff[0] ? {1'b0, pb_ff[52:27]} : pb_ff[26:0];
      pp      = op_x * op_y;
      pp_sh   = (cnt_ff[1] ? 7'd27 : 7'd0) + (cnt_ff[0] ? 7'd27 : 7'd0);
      mul_acc = m_ff + (MW'(pp) << pp_sh);
      add_sum = eff_sub_ff ? (big_ff - m_ff) : (big_ff + m_ff);

      mant    = m_ff[127:75];
      rnd_inc = m_ff[74] && ((|m_ff[73:0]) || mant[0]);
      rsum    = {1'b0, mant} + 54'(rnd_inc);
      if (rsum[53]) begin
         mant_r = rsum[53:1];
         exp_r  = exp_ff + 14'sd1;
      end else begin
         mant_r = rsum[52:0];
         exp_r  = exp_ff;
      end
      if (exp_r >= 14'sd2047)
         rnd_val = {sign_ff, 11'h7FF, 52'd0};
      else
         rnd_val = {sign_ff, mant_r[52] ? exp_r[10:0] : 11'd0, mant_r[51:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req.start) begin
                  if (spec) begin
                     res_ff   <= spec_val;
                     state_ff <= F_DONE;
                  end else if (req.op == FPU_MUL) begin
                     sign_ff  <= sa ^ sb;
                     exp_ff   <= 14'(ea_eff) + 14'(eb_eff) - 14'sd1000;
                     pa_ff    <= ma;
                     pb_ff    <= mb;
                     m_ff     <= '0;
                     cnt_ff   <= 2'd0;
                     state_ff <= F_MUL;
                  end else begin
                     // larger magnitude stays, smaller is aligned with sticky
                     if (a_big) begin
                        big_ff  <= {1'b0, ma, 74'd0};
                        m_ff    <= {1'b0, mb, 74'd0};
                        sign_ff <= sa;
                        exp_ff  <= 14'(ea_eff) + 14'sd1;
                     end else begin
                        big_ff  <= {1'b0, mb, 74'd0};
                        m_ff    <= {1'b0, ma, 74'd0};
                        sign_ff <= ~sb;
                        exp_ff  <= 14'(eb_eff) + 14'sd1;
                     end
                     eff_sub_ff  <= (sa == sb);
                     sh_ff       <= align_sh;
                     lvl_ff      <= 3'd7;
                     to_round_ff <= 1'b0;
                     state_ff    <= F_SHIFT;
                  end
               end
            end
            F_MUL: begin
               m_ff   <= mul_acc;
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  lvl_ff   <= 3'd6;
                  state_ff <= F_NORM;
               end
            end
            F_SHIFT: begin
               if (sh_ff[lvl_ff]) m_ff <= shr_val;
               lvl_ff <= lvl_ff - 3'd1;
               if (lvl_ff == 3'd0) state_ff <= to_round_ff ? F_ROUND : F_ADD;
            end
            F_ADD: begin
               if (add_sum == '0) begin
                  res_ff   <= 64'd0;
                  state_ff <= F_DONE;
               end else begin
                  m_ff     <= add_sum;
                  lvl_ff   <= 3'd6;
                  state_ff <= F_NORM;
               end
            end
            F_NORM: begin
               m_ff <= norm_val;
               if ((lvl_ff == 3'd0) && (norm_exp < 14'sd1)) begin
                  // subnormal result: shift down to the minimum exponent
                  exp_ff      <= 14'sd1;
                  sh_ff       <= denorm_sh;
                  lvl_ff      <= 3'd7;
                  to_round_ff <= 1'b1;
                  state_ff    <= F_SHIFT;
               end else begin
                  exp_ff <= norm_exp;
                  lvl_ff <= lvl_ff - 3'd1;
                  if (lvl_ff == 3'd0) state_ff <= F_ROUND;
               end
            end
            F_ROUND: begin
               res_ff   <= rnd_val;
               state_ff <= F_DONE;
            end
            F_DONE: state_ff <= F_IDLE;
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign rsp.done   = (state_ff == F_DONE);
   assign rsp.result = res_ff;

endmodule

FILE: verif/sparse_triangular_row_solver_core_checker.sv
// ----------------------------------------------------------------------------
// Sparse triangular row solver: stream checker
// Watches both channels of the core, keeps its own copy of the solution store
// and the row accumulator, predicts each solved row and compares it with what
// the core returns, oldest first.
// ----------------------------------------------------------------------------
module sparse_triangular_row_solver_core_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [sptrs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [sptrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                               error_count,
   output int                               rows_pending
);
   import sptrs_pkg::*;

   typedef struct packed {
      logic [15:0] row;
      logic [63:0] value;
   } solved_row_type;

   logic [63:0]    x_store [0:65535];
   logic [63:0]    running_sum;
   solved_row_type solved_q [$];

   function automatic logic [63:0] dmul(input logic [63:0] a, input logic [63:0] b);
      return $realtobits($bitstoreal(a) * $bitstoreal(b));
   endfunction

   function automatic logic [63:0] dsub(input logic [63:0] a, input logic [63:0] b);
      return $realtobits($bitstoreal(a) - $bitstoreal(b));
   endfunction

   function automatic bit is_nan(input logic [63:0] v);
      return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // fold one accepted request into the running state
   task automatic solve_entry(input logic [REQ_DATA_W-1:0] d, input logic first,
                              input logic last);
      logic [15:0] row;
      logic [63:0] rhs, coef, xv;
      logic [15:0] col;
      solved_row_type s;
      row  = d[ROW_LSB +: 16];
      rhs  = d[RHS_LSB +: 64];
      coef = d[COEF_LSB +: 64];
      col  = d[COL_LSB +: 16];
      if (first) running_sum = rhs;
      if (last) begin
         s.row   = row;
         s.value = dmul(running_sum, coef);
         x_store[row] = s.value;
         solved_q.push_back(s);
      end else begin
         xv = x_store[col];
         running_sum = dsub(running_sum, dmul(coef, xv));
      end
   endtask

   always @(posedge clock) begin
      solved_row_type s;
      logic [63:0] got;
      if (reset) begin
         running_sum = 64'd0;
         solved_q.delete();
      end else begin
         if (req_tvalid && req_tready) solve_entry(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (solved_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[63:0], 64'd0);
            end else begin
               s = solved_q.pop_front();
               got = rsp_tdata[79:16];
               if (rsp_tdata[15:0] !== s.row)
                  report_mismatch("solved_row", {48'd0, rsp_tdata[15:0]}, {48'd0, s.row});
               // NaN payloads are not fixed by IEEE; any NaN stands for a NaN
               if (!(is_nan(s.value) && is_nan(got)) && got !== s.value)
                  report_mismatch("solution_bits", got, s.value);
            end
         end
      end
      rows_pending = solved_q.size();
   end

   initial begin
      error_count  = 0;
      rows_pending = 0;
      running_sum  = 64'd0;
   end

endmodule

FILE: verif/sparse_triangular_row_solver_core_tb.sv
// ----------------------------------------------------------------------------
// Sparse triangular row solver: testbench top
// Streams directed and random CSR rows in dependency order into the core,
// stalls the response side on its own pattern and gives the verdict from the
// checker's mismatch count.
// ----------------------------------------------------------------------------
module sparse_triangular_row_solver_core_tb;
   import sptrs_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    error_count;
   int                    rows_pending;

   bit        solved_mask [0:65535];
   int        solved_list [$];
   int        burst_left;
   bit        long_hold;
   int        cycle_count;

   localparam int CYCLE_LIMIT = 600000;

   sparse_triangular_row_solver_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   sparse_triangular_row_solver_core_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .rows_pending(rows_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("sparse_triangular_row_solver_core_tb NOT OK");
            $finish;
         end
      end
   end

   // response side: stall modes of random length, plus long hold-offs
   initial begin
      int mode, span;
      rsp_tready = 1'b0;
      mode = 0;
      span = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 80);
         end
         span--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1: return {$urandom, $urandom};
         2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h7FF, 52'd0};
         3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'd0, $urandom, 20'(
                    $urandom)};
         default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                          11'($urandom_range(1013, 1033)), $urandom, 20'($urandom)};
      endcase
   endfunction

   function automatic logic [15:0] pick_solved_column();
      return 16'(solved_list[$urandom_range(0, solved_list.size() - 1)]);
   endfunction

   // offer one request; bursts of back-to-back requests with random gaps
   task automatic send_entry(input logic [15:0] row, input logic [63:0] rhs,
                             input logic [63:0] coef, input logic [15:0] col,
                             input logic first, input logic last);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {col, coef, rhs, row};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (last && !solved_mask[row]) begin
         solved_mask[row] = 1'b1;
         solved_list.push_back(row);
      end
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   // a well-formed row: first entry, off-diagonals on solved columns, diagonal
   task automatic send_row(input logic [15:0] row, input int n_off);
      logic [63:0] rhs;
      rhs = pick_value();
      if (solved_list.size() == 0) n_off = 0;
      for (int k = 0; k < n_off; k++)
         send_entry(row, k == 0 ? rhs : pick_value(), pick_value(),
                    pick_solved_column(), k == 0, 1'b0);
      send_entry(row, rhs, pick_value(), 16'($urandom), n_off == 0, 1'b1);
   endtask

   initial begin
      int sent;
      logic [15:0] row;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      long_hold  = 1'b0;
      burst_left = 0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // diagonal-only rows at the index extremes and with special values
      send_entry(16'h0000, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 16'hFFFF,
                 1'b1, 1'b1);
      send_entry(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 16'h0000,
                 1'b1, 1'b1);
      send_entry(16'h0001, 64'h7FF0_0000_0000_0000, 64'h0000_0000_0000_0000, 16'h0,
                 1'b1, 1'b1);
      send_entry(16'h0002, 64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 16'h0,
                 1'b1, 1'b1);
      send_entry(16'h0003, 64'h7FEF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, 16'h0,
                 1'b1, 1'b1);
      send_entry(16'h0004, 64'h8000_0000_0000_0000, 64'hFFF0_0000_0000_0000, 16'h0,
                 1'b1, 1'b1);
      // off-diagonals reading both extreme columns
      send_entry(16'h0005, 64'h4008_0000_0000_0000, 64'h3FF8_0000_0000_0000, 16'h0000,
                 1'b1, 1'b0);
      send_entry(16'h0005, 64'h0, 64'h0000_0000_0000_0000, 16'hFFFF, 1'b0, 1'b0);
      send_entry(16'h0005, 64'h0, 64'h3FD0_0000_0000_0000, 16'h0002, 1'b0, 1'b1);
      // missing first: the accumulator carries over from the last row
      send_entry(16'h0006, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 16'h0003,
                 1'b0, 1'b0);
      send_entry(16'h0006, 64'h0, 64'hBFF0_0000_0000_0000, 16'h1234, 1'b0, 1'b1);
      send_entry(16'h0007, 64'h0, 64'h4000_0000_0000_0000, 16'h5678, 1'b0, 1'b1);
      send_entry(16'h0008, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 16'h0001,
                 1'b1, 1'b0);
      send_entry(16'h0008, 64'h0, 64'h3FF0_0000_0000_0000, 16'h0004, 1'b0, 1'b1);

      sent = 0;
      while (sent < 500) begin
         // hold the response side off while requests keep coming; later, drain the core with the sender idle
         if (sent >= 150 && sent < 156) long_hold = 1'b1;
         if (sent >= 300 && sent < 306) begin
            idle_sender();
            wait (rows_pending == 0);
            @(negedge clock);
         end
         row = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
         if ($urandom_range(0, 9) == 0) begin
            // broken run: off-diagonals without a starting entry or an end
            repeat ($urandom_range(1, 3)) begin
               send_entry(row, pick_value(), pick_value(), pick_solved_column(),
                          1'b0, 1'b0);
               sent++;
            end
         end else begin
            int n_off;
            n_off = $urandom_range(0, 4);
            send_row(row, n_off);
            sent += n_off + 1;
         end
      end
      idle_sender();
      wait (rows_pending == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("sparse_triangular_row_solver_core_tb OK");
      else
         $display("sparse_triangular_row_solver_core_tb NOT OK");
      $finish;
   end

endmodule
